>>> rtl/tcspg_pkg.sv
// Shared types, codes and the pulse width band table for the servo pulse generator.
package tcspg_pkg;

    // Default count of software pulse channels
    localparam int NUM_CHANNELS_DEF = 3;

    // Word field widths
    localparam int ADC_W       = 10;
    localparam int OP_W        = 2;
    localparam int WIDTH_W     = 4;
    localparam int TICK_W      = 8;
    localparam int FRAME_W     = 5;
    localparam int OFFSET_W    = 8;
    localparam int DUTY_W      = 10;
    localparam int LINES_W     = 3;
    localparam int SEL_OUT_W   = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // Register reset values
    localparam logic [FRAME_W-1:0]  FRAME_LENGTH_RST = 5'd20;
    localparam logic [OFFSET_W-1:0] SERVO_OFFSET_RST = 8'd124;
    localparam logic [DUTY_W-1:0]   DUTY_RST         = 10'd60;

    // Word kinds carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_FINE   = 2'd1,
        OP_FRAME  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_LENGTH = 1'd0,
        REG_SERVO_OFFSET = 1'd1
    } reg_idx_t;

    // Per-channel control for one accepted word
    typedef struct packed {
        logic fine_tick;
        logic enable_all;
        logic set_line;
        logic load_width;
    } chan_ctrl_t;

    // Band table: upper limits and the pulse widths they select
    localparam int NUM_LIMITS = 11;
    typedef logic [7:0]         limit_arr_t [NUM_LIMITS];
    typedef logic [WIDTH_W-1:0] width_arr_t [NUM_LIMITS+1];

    localparam limit_arr_t BAND_LIMIT = '{
        8'd19, 8'd40, 8'd61, 8'd82, 8'd103, 8'd131,
        8'd152, 8'd173, 8'd194, 8'd215, 8'd236
    };
    localparam width_arr_t BAND_WIDTH = '{
        4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15
    };

    // Quantize the top 8 sample bits into a pulse width; first band that fits wins
    function automatic logic [WIDTH_W-1:0] quantize(input logic [7:0] v);
        logic [WIDTH_W-1:0] w;
        w = BAND_WIDTH[NUM_LIMITS];
        for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
            if (v < BAND_LIMIT[i]) begin
                w = BAND_WIDTH[i];
            end
        end
        return w;
    endfunction

endpackage

>>> rtl/three_channel_servo_pulse_generator.sv
// Top level of the servo pulse generator: word decode, frame counter, servo duty, output register.
//
// Input words arrive on the s_ stream: s_tuser carries the kind (ADC sample, fine tick,
// frame tick; the fourth code changes nothing) and s_tdata the 10-bit ADC value.
// ADC samples go round-robin over the pulse channels and then the servo channel.
// Every accepted word yields exactly one result word on the m_ stream: the pulse line
// levels, the servo duty and the channel the next sample will go to, all taken after
// the word's update.
// The result is registered: a word accepted at one edge has its result valid after it.
// The block takes one word per cycle while the receiver keeps up; the state update is a single
// compare-and-count pass between the state registers and the result register.
// s_tready is high while the result register is empty or being drained, so a stalled
// receiver holds its result and the block takes no further word until it is taken.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at the next edge and
// are meant for idle periods.
// Synchronous active-low reset clears all counters, enables and line levels, sets the
// duty to 60, frame length to 20 and servo offset to 124, and empties the result register;
// s_tready stays low while reset is held.
module three_channel_servo_pulse_generator #(
    parameter int NUM_CHANNELS = tcspg_pkg::NUM_CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [tcspg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tcspg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tcspg_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] adc_value
    input  logic [tcspg_pkg::OP_W-1:0]       s_tuser,  // [1:0] op
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tcspg_pkg::M_TDATA_W-1:0]  m_tdata   // [2:0] pulse_lines,
                                                       // [12:3] servo_duty,
                                                       // [14:13] sample_channel
);
    import tcspg_pkg::*;

    localparam int SEL_W = (NUM_CHANNELS + 1 > 1) ? $clog2(NUM_CHANNELS + 1) : 1;
    localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NUM_CHANNELS);

    logic [FRAME_W-1:0]  frame_length_reg;
    logic [OFFSET_W-1:0] servo_offset_reg;
    logic [SEL_W-1:0]    sel_reg, sel_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                accept;
    op_t                 op;
    logic [ADC_W-1:0]    adc;
    logic [WIDTH_W-1:0]  width_q;
    logic [OFFSET_W-1:0] duty_high;
    logic [NUM_CHANNELS-1:0] level_next;
    logic [LINES_W-1:0]  lines_next;
    chan_ctrl_t          ctrl [NUM_CHANNELS];

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign adc      = s_tdata[ADC_W-1:0];
    assign width_q  = quantize(adc[ADC_W-1:2]);
    assign duty_high = OFFSET_W'(adc[ADC_W-1:3]) + servo_offset_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= FRAME_LENGTH_RST;
            servo_offset_reg <= SERVO_OFFSET_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_FRAME_LENGTH: frame_length_reg <= cfg_wdata[FRAME_W-1:0];
                REG_SERVO_OFFSET: servo_offset_reg <= cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel select, frame counter and servo duty
    always_comb begin
        sel_next   = sel_reg;
        frame_next = frame_reg;
        duty_next  = duty_reg;
        if (accept) begin
            case (op)
                OP_SAMPLE: begin
                    if (sel_reg < LAST_SEL) begin
                        sel_next = sel_reg + 1'b1;
                    end else begin
                        duty_next = {duty_high, adc[2], adc[1]};
                        sel_next  = '0;
                    end
                end
                OP_FRAME: begin
                    if (frame_reg == frame_length_reg) begin
                        frame_next = FRAME_W'(1);
                    end else begin
                        frame_next = frame_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-channel controls
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            ctrl[i].fine_tick  = accept && (op == OP_FINE);
            ctrl[i].enable_all = accept && (op == OP_FRAME) && (frame_reg == FRAME_W'(1));
            ctrl[i].set_line   = accept && (op == OP_FRAME) && (frame_reg == frame_length_reg);
            ctrl[i].load_width = accept && (op == OP_SAMPLE) && (sel_reg == SEL_W'(i));
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        tcspg_channel u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[g]),
            .width_in   (width_q),
            .level_next (level_next[g])
        );
    end

    // Only the first three lines are reported
    for (genvar g = 0; g < LINES_W; g++) begin : g_lines
        if (g < NUM_CHANNELS) begin : g_on
            assign lines_next[g] = level_next[g];
        end else begin : g_off
            assign lines_next[g] = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg   <= '0;
            frame_reg <= '0;
            duty_reg  <= DUTY_RST;
        end else begin
            sel_reg   <= sel_next;
            frame_reg <= frame_next;
            duty_reg  <= duty_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {1'b0, SEL_OUT_W'(sel_next), duty_next, lines_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Channel select stays within the channel count
    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg <= LAST_SEL)
        else $error("channel select out of range");

    // A sample on the servo channel wraps the select to zero
    a_sel_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_SAMPLE && sel_reg == LAST_SEL) |=> (sel_reg == '0))
        else $error("channel select did not wrap");

    // End of frame restarts the count at one
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_FRAME && frame_reg == frame_length_reg) |=> (frame_reg == 1))
        else $error("frame counter did not restart");

    // Every accepted word leaves a result waiting
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word produced no result");

endmodule

>>> rtl/tcspg_channel.sv
// One software pulse channel: width store, fine tick counter and line level.
module tcspg_channel (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tcspg_pkg::chan_ctrl_t        ctrl,
    input  logic [tcspg_pkg::WIDTH_W-1:0] width_in,
    output logic                         level_next
);
    import tcspg_pkg::*;

    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               enable_reg, enable_next;
    logic               level_reg;
    logic               hit;

    assign hit = (tick_reg == TICK_W'(width_reg));

    // Next state for the accepted word
    always_comb begin
        width_next  = width_reg;
        tick_next   = tick_reg;
        enable_next = enable_reg;
        level_next  = level_reg;
        if (ctrl.load_width) begin
            width_next = width_in;
        end
        if (ctrl.fine_tick) begin
            if (hit) begin
                level_next  = 1'b0;
                tick_next   = '0;
                enable_next = 1'b0;
            end else if (enable_reg) begin
                tick_next = tick_reg + 1'b1;
            end
        end
        if (ctrl.enable_all) begin
            enable_next = 1'b1;
        end
        if (ctrl.set_line) begin
            level_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            tick_reg   <= '0;
            enable_reg <= 1'b0;
            level_reg  <= 1'b0;
        end else begin
            width_reg  <= width_next;
            tick_reg   <= tick_next;
            enable_reg <= enable_next;
            level_reg  <= level_next;
        end
    end

    // Reaching the width drops the line and stops the counter
    a_hit_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.fine_tick && hit) |=> (!level_reg && tick_reg == '0 && !enable_reg))
        else $error("pulse line did not drop at width");

    // A counter only moves while enabled or when it clears
    a_tick_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!enable_reg && !ctrl.fine_tick) |=> $stable(tick_reg))
        else $error("tick counter moved while stopped");

endmodule
